### sv/tdpt_pkg.sv
// Package for the trial-division prime test core.
// Shared constants for the sequencer and the remainder unit; no dependencies.
package tdpt_pkg;

    // Default width of the tested value, sign bit included
    localparam int DEF_VALUE_WIDTH = 32;

    // Trial divisor sequence: 3, 5, 7, ...
    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;

    // The smallest prime
    localparam int SMALLEST_PRIME = 2;

    // Result beat width (one flag, padded to a byte)
    localparam int RESULT_TDATA_W = 8;

endpackage

### sv/trial_division_prime_test_core.sv
// Top level of the trial-division prime test core: sequencer, divisor
// register and output register around one shared divider.
// Depends on tdpt_pkg and tdpt_divider.
//
// Channel   Dir  Width          Content
// s_axis    in   ceil(W/8)*8    candidate, signed, bits [W-1:0]
// m_axis    out  8              is_prime in bit 0
//
// Operation: one beat is checked against divisors 3, 5, 7, ... until one
//   divides it or the divisor passes n/d. Each divisor takes a start step,
//   W restoring steps and a step that checks the result. Up to ~23170
//   divisors are tried at W = 32. Negative values, 0, 1, 2 and other even
//   values are settled in the classify state without the divider.
// Stalls: s_axis_tready is high only in idle. A result waiting in the output
//   register does not block the next beat; the sequencer holds its result
//   only if the output register is still full when it finishes.
// Reset: rst_n clears the sequencer state, the divider control and output valid.
module trial_division_prime_test_core
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // [W-1:0] candidate
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [RESULT_TDATA_W-1:0]      m_axis_tdata     // [0] is_prime
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CLASS = 4'b0010,
        S_DIV   = 4'b0100,
        S_HOLD  = 4'b1000
    } state_t;

    localparam logic [VALUE_WIDTH-1:0] D_FIRST = VALUE_WIDTH'(FIRST_DIVISOR);
    localparam logic [VALUE_WIDTH-1:0] D_STEP  = VALUE_WIDTH'(DIVISOR_STEP);
    localparam logic [VALUE_WIDTH-1:0] V_TWO   = VALUE_WIDTH'(SMALLEST_PRIME);

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] cand_reg, cand_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic                   res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_prime_reg, out_prime_next;

    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;
    logic                   out_free;

    tdpt_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (cand_reg),
        .divisor   (dvs_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        cand_next  = cand_reg;
        dvs_next   = dvs_reg;
        res_next   = res_reg;
        div_start  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cand_next  = s_axis_tdata[VALUE_WIDTH-1:0];
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                // negative, 0 and 1 are not prime; 2 is; other evens are not
                if (cand_reg[VALUE_WIDTH-1] || cand_reg < V_TWO)
                begin
                    res_next   = 1'b0;
                    state_next = S_HOLD;
                end
                else if (cand_reg == V_TWO)
                begin
                    res_next   = 1'b1;
                    state_next = S_HOLD;
                end
                else if (!cand_reg[0])
                begin
                    res_next   = 1'b0;
                    state_next = S_HOLD;
                end
                else
                begin
                    dvs_next   = D_FIRST;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (dvs_reg > div_quo)
                    begin
                        // d*d > n: no divisor left
                        res_next   = 1'b1;
                        state_next = S_HOLD;
                    end
                    else if (div_rem == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = S_HOLD;
                    end
                    else
                    begin
                        dvs_next = dvs_reg + D_STEP;
                    end
                end
                else if (!div_busy)
                begin
                    div_start = 1'b1;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_HOLD && out_free)
        begin
            out_valid_next = 1'b1;
            out_prime_next = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg      <= cand_next;
        dvs_reg       <= dvs_next;
        res_reg       <= res_next;
        out_prime_reg <= out_prime_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(RESULT_TDATA_W-1){1'b0}}, out_prime_reg};

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg == S_CLASS)
        else $error("accepted beat did not start classification");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_divisor_odd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dvs_reg[0] && dvs_reg >= D_FIRST)
        else $error("trial divisor not odd or below three");

    a_load_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(state_reg == S_HOLD))
        else $error("result loaded without a finished item");

endmodule

### sv/tdpt_divider.sv
// Restoring divider, one quotient bit per cycle, for the prime test core.
// Depends on tdpt_pkg (default width).
module tdpt_divider
    import tdpt_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   busy,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [VALUE_WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   last_step;

    assign trial     = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign last_step = (cnt_reg == CNT_W'(VALUE_WIDTH - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            // partial remainder stays below the divisor, so W bits hold it
            if (!diff[VALUE_WIDTH])
            begin
                rem_next = diff[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    // done pulses once, right after the final step
    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a finished run");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < dsr_reg)
        else $error("divider remainder not below divisor");

endmodule
